// ===== hw/rtl/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// types and constants shared by the beep pattern sequencer modules
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

  localparam int unsigned FREQ_W    = 16;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned TOTAL_W   = TIME_W + 1;
  localparam int unsigned ELAPSED_W = 18;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned COUNT_W   = 16;

  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = PERIOD_W'(1);

  // input item opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_SOUND = 2'd2,
    PH_QUIET = 2'd3
  } phase_t;

  typedef struct packed {
    logic              opcode;
    logic [FREQ_W-1:0] tone_freq;
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] off_time;
    logic [COUNT_W-1:0] repeat_count;
  } bps_in_t;

  typedef struct packed {
    logic              drive_update;
    logic [FREQ_W-1:0] drive_freq;
  } bps_out_t;

  // classified command handed from front to back
  typedef struct packed {
    logic               load;
    logic               silent;
    logic               continuous;
    logic [FREQ_W-1:0]  freq;
    logic [TIME_W-1:0]  on_time;
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] cycles;
  } bps_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/beep_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// beep_pattern_sequencer
// tick driven tone on/off pattern sequencer with queue style ports
// ----------------------------------------------------------------------------
// every input transfer is one tick; with opcode set it first loads a new
// pattern (frequency, on time, off time, repeat count) and restarts it.
// every tick gives exactly one result: drive_update tells whether the tone
// drive was set on that tick, drive_freq is the value it now holds (0 is
// off). the block takes one tick per clock: the pattern state is updated in
// the back stage, so throughput is one transfer per cycle as long as results
// are popped. a tick's result reaches the result ports through the command
// queue register, then the back stage writes the result queue; a full result
// queue stalls it in between. tick_period may be written any time the block
// is idle; cfg_ready is always high.
`default_nettype none

module beep_pattern_sequencer
  import bps_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2,   // front to back command queue
  parameter int unsigned OUT_DEPTH   = 2    // result queue
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // tick input
  input  wire logic                in_push,
  input  wire bps_in_t             in_item,
  output logic                     in_full,
  // results
  output bps_out_t                 out_item,
  output logic                     out_empty,
  input  wire logic                out_pop,
  // tick period register
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [PERIOD_W-1:0] cfg_tick_period
);

  bps_cmd_t cmd;
  logic     cmd_empty;
  logic     cmd_pop;

  // register writes never stall
  assign cfg_ready = 1'b1;

  // front: takes ticks, classifies loads, buffers commands
  bps_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  // back: runs the pattern state and queues one result per tick
  bps_back #(
    .DEPTH (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_period (cfg_tick_period),
    .out_item   (out_item),
    .out_empty  (out_empty),
    .out_pop    (out_pop)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bps_fifo.sv =====
// ----------------------------------------------------------------------------
// bps_fifo
// small register queue, one push and one pop per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bps_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bps_front.sv =====
// ----------------------------------------------------------------------------
// bps_front
// accepts ticks, classifies pattern loads and queues commands for the back
// ----------------------------------------------------------------------------
`default_nettype none

module bps_front
  import bps_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_push,
  input  wire bps_in_t in_item,
  output logic         in_full,
  input  wire logic    cmd_pop,
  output bps_cmd_t     cmd,
  output logic         cmd_empty
);

  bps_cmd_t cmd_in;

  // pattern classification done once at load time
  always_comb begin
    cmd_in            = '0;
    cmd_in.load       = (in_item.opcode == OP_LOAD);
    cmd_in.silent     = (in_item.on_time == '0) || (in_item.tone_freq == '0);
    cmd_in.continuous = (in_item.off_time == '0);
    cmd_in.freq       = in_item.tone_freq;
    cmd_in.on_time    = in_item.on_time;
    cmd_in.total      = {1'b0, in_item.on_time} + {1'b0, in_item.off_time};
    cmd_in.cycles     = in_item.repeat_count;
  end

  bps_fifo #(
    .WIDTH ($bits(bps_cmd_t)),
    .DEPTH (DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (cmd_in),
    .full    (in_full),
    .pop     (cmd_pop),
    .rd_data (cmd),
    .empty   (cmd_empty)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bps_back.sv =====
// ----------------------------------------------------------------------------
// bps_back
// per-tick pattern state update and result queue
// ----------------------------------------------------------------------------
`default_nettype none

module bps_back
  import bps_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bps_cmd_t            cmd,
  input  wire logic                cmd_empty,
  output logic                     cmd_pop,
  input  wire logic                cfg_wr,
  input  wire logic [PERIOD_W-1:0] cfg_period,
  output bps_out_t                 out_item,
  output logic                     out_empty,
  input  wire logic                out_pop
);

  phase_t               phase_r, phase_nxt, ph;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [FREQ_W-1:0]    held_freq_r, held_freq_nxt;
  logic [TIME_W-1:0]    held_on_r, held_on_nxt;
  logic [TOTAL_W-1:0]   held_total_r, held_total_nxt;
  logic [COUNT_W-1:0]   cycles_left_r, cycles_left_nxt;
  logic [FREQ_W-1:0]    last_drive_r, last_drive_nxt;
  logic [PERIOD_W-1:0]  tick_period_r;
  logic [ELAPSED_W:0]   sum;
  logic [ELAPSED_W-1:0] adv;
  logic                 upd;
  logic [FREQ_W-1:0]    drv;
  logic                 out_full;
  bps_out_t             res;

  assign cmd_pop = !cmd_empty && !out_full;

  // saturating advance of the elapsed counter
  assign sum = {1'b0, elapsed_r} + (ELAPSED_W + 1)'(tick_period_r);
  assign adv = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];

  always_comb begin
    held_freq_nxt   = cmd.load ? cmd.freq    : held_freq_r;
    held_on_nxt     = cmd.load ? cmd.on_time : held_on_r;
    held_total_nxt  = cmd.load ? cmd.total   : held_total_r;
    cycles_left_nxt = cmd.load ? cmd.cycles  : cycles_left_r;
    ph              = cmd.load ? PH_START    : phase_r;
    phase_nxt       = ph;
    elapsed_nxt     = elapsed_r;
    upd             = 1'b0;
    drv             = '0;
    case (ph)
      PH_START: begin
        upd       = 1'b1;
        phase_nxt = PH_IDLE;
        if (!cmd.silent) begin
          drv = cmd.freq;
          if (!cmd.continuous) begin
            elapsed_nxt = '0;
            phase_nxt   = PH_SOUND;
          end
        end
      end
      PH_SOUND: begin
        elapsed_nxt = adv;
        if (adv >= ELAPSED_W'(held_on_nxt)) begin
          upd       = 1'b1;
          phase_nxt = PH_QUIET;
        end
      end
      PH_QUIET: begin
        elapsed_nxt = adv;
        if (adv >= ELAPSED_W'(held_total_nxt)) begin
          elapsed_nxt = adv - ELAPSED_W'(held_total_nxt);
          upd         = 1'b1;
          if (cycles_left_nxt == COUNT_W'(1)) begin
            phase_nxt = PH_IDLE;
          end else begin
            drv       = held_freq_nxt;
            phase_nxt = PH_SOUND;
            if (cycles_left_nxt != '0) begin
              cycles_left_nxt = cycles_left_nxt - COUNT_W'(1);
            end
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    last_drive_nxt   = upd ? drv : last_drive_r;
    res.drive_update = upd;
    res.drive_freq   = last_drive_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      elapsed_r     <= '0;
      held_freq_r   <= '0;
      held_on_r     <= '0;
      held_total_r  <= '0;
      cycles_left_r <= '0;
      last_drive_r  <= '0;
    end else if (cmd_pop) begin
      phase_r       <= phase_nxt;
      elapsed_r     <= elapsed_nxt;
      held_freq_r   <= held_freq_nxt;
      held_on_r     <= held_on_nxt;
      held_total_r  <= held_total_nxt;
      cycles_left_r <= cycles_left_nxt;
      last_drive_r  <= last_drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= TICK_PERIOD_RST;
    end else if (cfg_wr) begin
      tick_period_r <= cfg_period;
    end
  end

  bps_fifo #(
    .WIDTH ($bits(bps_out_t)),
    .DEPTH (DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_pop),
    .wr_data (res),
    .full    (out_full),
    .pop     (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bps_checker.sv =====
// ----------------------------------------------------------------------------
// bps_checker
// port level checks for the beep pattern sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module bps_checker
  import bps_pkg::*;
#(
  parameter int unsigned MAX_PENDING = 4
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_push,
  input wire bps_in_t             in_item,
  input wire logic                in_full,
  input wire bps_out_t            out_item,
  input wire logic                out_empty,
  input wire logic                out_pop,
  input wire logic                cfg_valid,
  input wire logic                cfg_ready,
  input wire logic [PERIOD_W-1:0] cfg_tick_period
);

  localparam int unsigned PEND_W = $clog2(MAX_PENDING + 2);

  logic [PEND_W-1:0] pending_r;
  logic [FREQ_W-1:0] last_freq_r;
  logic              in_xfer, out_xfer;

  assign in_xfer  = in_push && !in_full;
  assign out_xfer = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      last_freq_r <= '0;
    end else begin
      pending_r <= pending_r + PEND_W'(in_xfer) - PEND_W'(out_xfer);
      if (out_xfer) begin
        last_freq_r <= out_item.drive_freq;
      end
    end
  end

  // the result queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result side not empty after reset");

  // a tick that does not set the drive repeats the previous drive value
  a_hold_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.drive_update) |-> (out_item.drive_freq == last_freq_r))
    else $error("drive value changed without an update");

  // a result only exists for a tick that was taken
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (pending_r != '0))
    else $error("result shown with no tick outstanding");

  // the queues never hold more than their capacity
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= PEND_W'(MAX_PENDING))
    else $error("more ticks outstanding than queue capacity");

  // input backpressure only when something is buffered
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> (pending_r != '0))
    else $error("input full with nothing outstanding");

  // configuration channel and tick payload are observed only
  logic unused_ok;
  assign unused_ok = ^{cfg_valid, cfg_ready, cfg_tick_period, in_item};

endmodule

bind beep_pattern_sequencer bps_checker #(
  .MAX_PENDING (QUEUE_DEPTH + OUT_DEPTH)
) u_bps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_push         (in_push),
  .in_item         (in_item),
  .in_full         (in_full),
  .out_item        (out_item),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .cfg_valid       (cfg_valid),
  .cfg_ready       (cfg_ready),
  .cfg_tick_period (cfg_tick_period)
);

`default_nettype wire
